// ===== src/assert_macros.svh =====
// Assertion macros shared by the set-cover fitness RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/scfe_pkg.sv =====
// Types and constants of the set-cover fitness evaluator
`timescale 1ns / 1ps
`default_nettype none

package scfe_pkg;

    localparam int unsigned ROW_W      = 64;
    localparam int unsigned COL_IDX_W  = 6;
    localparam int unsigned FIT_W      = 15;
    localparam int unsigned CNT_W      = 7;
    localparam int unsigned PEN_W      = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned BYTES      = ROW_W / 8;
    localparam int unsigned BYTE_IDX_W = 3;

    localparam logic [FIT_W-1:0] FIT_MAX = 15'h7FFF;

    // Operation codes of an input word
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PENALTY = 2'd2;

    typedef struct packed {
        logic                 op;
        logic [COL_IDX_W-1:0] col_index;
        logic [ROW_W-1:0]     row_bits;
    } in_word_t;

    typedef struct packed {
        logic [FIT_W-1:0] fitness;
        logic             is_new_best;
        logic [FIT_W-1:0] best_fitness;
        logic [ROW_W-1:0] best_gene;
    } out_word_t;

endpackage

`default_nettype wire

// ===== src/scfe_cov_mem.sv =====
// Coverage mask memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module scfe_cov_mem #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6
) (
    input  wire                             clk,
    input  wire                             wr_en,
    input  wire  [ADDR_W-1:0]               wr_addr,
    input  wire  [scfe_pkg::ROW_W-1:0]      wr_data,
    input  wire                             rd_en,
    input  wire  [ADDR_W-1:0]               rd_addr,
    output logic [scfe_pkg::ROW_W-1:0]      rd_data
);

    logic [scfe_pkg::ROW_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/set_cover_fitness_evaluator_unit.sv =====
// Top level of the set-cover fitness evaluator
// Usage:
//   in_valid/in_ready/in_word carry one word per handshake. A load word
//   (op clear) writes the row mask of column col_index into the coverage
//   memory and gives no result. An evaluate word (op
//   set) carries a gene and gives one out_word: the fitness, whether it
//   beats the best so far, and the best fitness and gene after it.
//   An evaluation walks the coverage memory one column a cycle through its
//   read port; after the sweep the FINISH and DONE states follow, and DONE
//   registers the result once the output register is free. The gene
//   popcount is folded in one byte a cycle at the start of the sweep.
//   Words are handled one at a time; in_ready is high only while idle.
//   A finished result sits in the output register, so a following load can
//   be taken while the receiver stalls; an evaluation holds its result
//   until out_ready frees the register.
//   cfg_we/cfg_index/cfg_data write rows_in_use, cols_in_use and
//   uncovered_penalty; write them only while the block is idle.
//   Reset sets the best fitness to all ones, the best gene to zero and the
//   registers to 64, 64 and 10. The coverage memory is not cleared: load
//   every column in use before evaluating.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module set_cover_fitness_evaluator_unit #(
    parameter int unsigned MAX_ROWS = 64,
    parameter int unsigned MAX_COLS = 64
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  scfe_pkg::in_word_t                   in_word,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output scfe_pkg::out_word_t                  out_word,
    input  wire                                  cfg_we,
    input  wire  [scfe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [scfe_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int unsigned ADDR_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int unsigned STEP_TOP = (MAX_COLS > scfe_pkg::BYTES) ? MAX_COLS
                                                                    : scfe_pkg::BYTES;
    localparam int unsigned STEP_W   = $clog2(STEP_TOP + 1);

    // Sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + 4'(v[i]);
        end
        return n;
    endfunction

    // Configuration
    logic [scfe_pkg::CNT_W-1:0] rows_in_use_reg;
    logic [scfe_pkg::CNT_W-1:0] cols_in_use_reg;
    logic [scfe_pkg::PEN_W-1:0] penalty_reg;

    // Sequencer and datapath
    logic [1:0]                 state_reg,  state_next;
    logic [STEP_W-1:0]          step_reg,   step_next;
    logic                       rd_pend_reg, rd_pend_next;
    logic [scfe_pkg::ROW_W-1:0] gene_reg,   gene_next;
    logic [scfe_pkg::FIT_W-1:0] acc_reg,    acc_next;
    logic [scfe_pkg::CNT_W-1:0] pc_reg,     pc_next;
    logic [scfe_pkg::FIT_W-1:0] best_reg,   best_next;
    logic [scfe_pkg::ROW_W-1:0] best_gene_reg, best_gene_next;
    logic                       out_valid_reg, out_valid_next;
    scfe_pkg::out_word_t        out_word_reg,  out_word_next;

    logic                       in_acc;
    logic [scfe_pkg::CNT_W-1:0] rows_eff;
    logic [scfe_pkg::ROW_W-1:0] row_mask;
    logic [STEP_W-1:0]          cols_lim;
    logic [STEP_W-1:0]          step_lim;
    logic                       load_en;
    logic                       rd_en;
    logic [scfe_pkg::ROW_W-1:0] rd_data;
    logic [scfe_pkg::FIT_W:0]   pen_sum;
    logic [scfe_pkg::FIT_W:0]   fit_sum;
    logic [scfe_pkg::FIT_W-1:0] fit;
    logic                       out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Rows past the limit never count; zero rows means an empty gene
    assign rows_eff = (32'(rows_in_use_reg) > MAX_ROWS) ? scfe_pkg::CNT_W'(MAX_ROWS)
                                                        : rows_in_use_reg;
    assign row_mask = (rows_eff >= scfe_pkg::CNT_W'(scfe_pkg::ROW_W)) ? '1
                    : ((scfe_pkg::ROW_W'(1) << rows_eff) - scfe_pkg::ROW_W'(1));

    // Columns to sweep, clamped to the store depth; run at least one byte pass
    assign cols_lim = (32'(cols_in_use_reg) > MAX_COLS) ? STEP_W'(MAX_COLS)
                                                        : STEP_W'(cols_in_use_reg);
    assign step_lim = (cols_lim > STEP_W'(scfe_pkg::BYTES)) ? cols_lim
                                                            : STEP_W'(scfe_pkg::BYTES);

    // Loads outside the store are dropped
    assign load_en = in_acc && (in_word.op == scfe_pkg::OP_LOAD)
                     && (32'(in_word.col_index) < MAX_COLS);
    assign rd_en   = (state_reg == ST_SWEEP) && (step_reg < cols_lim);

    scfe_cov_mem #(
        .DEPTH  (MAX_COLS),
        .ADDR_W (ADDR_W)
    ) u_cov_mem (
        .clk     (clk),
        .wr_en   (load_en),
        .wr_addr (ADDR_W'(in_word.col_index)),
        .wr_data (in_word.row_bits),
        .rd_en   (rd_en),
        .rd_addr (step_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // Penalty add with saturation at the top of the fitness range
    assign pen_sum = {1'b0, acc_reg} + (scfe_pkg::FIT_W + 1)'(penalty_reg);
    assign fit_sum = {1'b0, acc_reg} + (scfe_pkg::FIT_W + 1)'(pc_reg);
    assign fit     = (fit_sum > {1'b0, scfe_pkg::FIT_MAX}) ? scfe_pkg::FIT_MAX
                                                          : fit_sum[scfe_pkg::FIT_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        rd_pend_next   = 1'b0;
        gene_next      = gene_reg;
        acc_next       = acc_reg;
        pc_next        = pc_reg;
        best_next      = best_reg;
        best_gene_next = best_gene_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;

        // Fold in the column read issued last cycle
        if (rd_pend_reg && ((rd_data & gene_reg) == '0))
        begin
            acc_next = (pen_sum > {1'b0, scfe_pkg::FIT_MAX}) ? scfe_pkg::FIT_MAX
                                                            : pen_sum[scfe_pkg::FIT_W-1:0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_word.op == scfe_pkg::OP_EVAL))
                begin
                    gene_next  = in_word.row_bits & row_mask;
                    acc_next   = '0;
                    pc_next    = '0;
                    step_next  = '0;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                rd_pend_next = rd_en;
                if (step_reg < STEP_W'(scfe_pkg::BYTES))
                begin
                    pc_next = pc_reg + scfe_pkg::CNT_W'(popcount8(
                        gene_reg[8*step_reg[scfe_pkg::BYTE_IDX_W-1:0] +: 8]));
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == step_lim - STEP_W'(1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold the result until the output register is free
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_word_next.fitness     = fit;
                    out_word_next.is_new_best = (fit < best_reg);
                    if (fit < best_reg)
                    begin
                        best_next                  = fit;
                        best_gene_next             = gene_reg;
                        out_word_next.best_fitness = fit;
                        out_word_next.best_gene    = gene_reg;
                    end
                    else
                    begin
                        out_word_next.best_fitness = best_reg;
                        out_word_next.best_gene    = best_gene_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            acc_reg       <= '0;
            pc_reg        <= '0;
            best_reg      <= scfe_pkg::FIT_MAX;
            best_gene_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            rd_pend_reg   <= rd_pend_next;
            acc_reg       <= acc_next;
            pc_reg        <= pc_next;
            best_reg      <= best_next;
            best_gene_reg <= best_gene_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        gene_reg     <= gene_next;
        out_word_reg <= out_word_next;
    end

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= 7'd64;
            cols_in_use_reg <= 7'd64;
            penalty_reg     <= 8'd10;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                scfe_pkg::CFG_ROWS:    rows_in_use_reg <= cfg_data[scfe_pkg::CNT_W-1:0];
                scfe_pkg::CFG_COLS:    cols_in_use_reg <= cfg_data[scfe_pkg::CNT_W-1:0];
                scfe_pkg::CFG_PENALTY: penalty_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // A read result is only ever pending during the sweep or the cycle after it
    `ASSERT_IMPLIES(a_rd_pend_in_sweep, clk, rst_n, rd_pend_reg,
        (state_reg == ST_SWEEP) || (state_reg == ST_FINISH))
    // The sweep counter never runs past its limit
    `ASSERT_IMPLIES(a_step_bound, clk, rst_n, state_reg == ST_SWEEP, step_reg < step_lim)
    // The reported best never exceeds the fitness of the same word
    `ASSERT_IMPLIES(a_best_le_fit, clk, rst_n, out_valid_reg,
        out_word_reg.best_fitness <= out_word_reg.fitness)
    // A new best is the reported fitness and is now the stored best
    `ASSERT_IMPLIES(a_new_best_stored, clk, rst_n,
        out_valid_reg && out_word_reg.is_new_best,
        (out_word_reg.best_fitness == out_word_reg.fitness) && (best_reg == out_word_reg.fitness))
    // Completing an evaluation returns to idle with a result registered
    `ASSERT_NEXT(a_done_result, clk, rst_n, (state_reg == ST_DONE) && out_free,
        out_valid_reg && (state_reg == ST_IDLE))

endmodule

`default_nettype wire
